### hdl/cbm_pkg.sv
`timescale 1ns / 1ps

package cbm_pkg;

    localparam int MODE_W      = 2;
    localparam int ADDR_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int TARGET_W    = 3;
    localparam int MAP_ADDR_W  = 21;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam int PRG_REGS    = 3;
    localparam int CHR_REGS    = 6;
    localparam int PRG_IDX_W   = $clog2(PRG_REGS);
    localparam int CHR_IDX_W   = $clog2(CHR_REGS);

    localparam int WRAM_DEPTH  = 256;
    localparam int WRAM_AW     = $clog2(WRAM_DEPTH);

    // access modes
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PPU   = 2'd2;

    // result targets
    localparam logic [TARGET_W-1:0] TGT_NONE = 3'd0;
    localparam logic [TARGET_W-1:0] TGT_WRAM = 3'd1;
    localparam logic [TARGET_W-1:0] TGT_PRG  = 3'd2;
    localparam logic [TARGET_W-1:0] TGT_CHR  = 3'd3;
    localparam logic [TARGET_W-1:0] TGT_NT   = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VARIANT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_MASK = 2'd2;

    // CPU register page and work RAM page
    localparam logic [11:0] REG_PAGE    = 12'h7EF;
    localparam logic [3:0]  REG_CHR_LAST = 4'h5;
    localparam logic [3:0]  REG_MIRROR  = 4'h6;
    localparam logic [3:0]  REG_PRG_FIRST = 4'hA;
    localparam logic [7:0]  WRAM_PAGE   = 8'h7F;

    typedef struct packed {
        logic                           variant;
        logic [BYTE_W-1:0]              prg_mask;
        logic [BYTE_W-1:0]              chr_mask;
        logic                           mirror;
        logic [PRG_REGS-1:0][BYTE_W-1:0] prg;
        logic [CHR_REGS-1:0][BYTE_W-1:0] chr;
    } bank_state_t;

endpackage

### hdl/cbm_if.sv
`timescale 1ns / 1ps

interface cbm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, output mode, output address, output write_data,
                    input ready);
    modport sink   (input valid, input mode, input address, input write_data,
                    output ready);
endinterface

interface cbm_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  target;
    logic [20:0] mapped_address;
    logic [7:0]  read_data;

    modport source (output valid, output target, output mapped_address,
                    output read_data, input ready);
    modport sink   (input valid, input target, input mapped_address,
                    input read_data, output ready);
endinterface

### hdl/cbm_regs.sv
`timescale 1ns / 1ps

module cbm_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  wr_en,
    input  logic [cbm_pkg::ADDR_W-1:0]            wr_addr,
    input  logic [cbm_pkg::BYTE_W-1:0]            wr_data,
    output cbm_pkg::bank_state_t                  state
);
    import cbm_pkg::*;

    bank_state_t state_reg;
    bank_state_t state_next;
    logic        reg_page;
    logic [3:0]  reg_sel;

    assign reg_page = (wr_addr[ADDR_W-1:4] == REG_PAGE);
    assign reg_sel  = wr_addr[3:0];

    always_comb
    begin
        state_next = state_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_VARIANT:  state_next.variant  = cfg_data[0];
                CFG_PRG_MASK: state_next.prg_mask = cfg_data;
                CFG_CHR_MASK: state_next.chr_mask = cfg_data;
                default:      state_next = state_reg;
            endcase
        end
        if (wr_en && reg_page)
        begin
            if (reg_sel <= REG_CHR_LAST)
            begin
                state_next.chr[reg_sel[CHR_IDX_W-1:0]] = wr_data;
            end
            else if (reg_sel == REG_MIRROR)
            begin
                state_next.mirror = wr_data[0];
            end
            else if (reg_sel >= REG_PRG_FIRST)
            begin
                // address pairs A/B, C/D, E/F
                case (reg_sel[2:1])
                    2'b01:   state_next.prg[PRG_IDX_W'(0)] = wr_data;
                    2'b10:   state_next.prg[PRG_IDX_W'(1)] = wr_data;
                    2'b11:   state_next.prg[PRG_IDX_W'(2)] = wr_data;
                    default: state_next.prg[PRG_IDX_W'(0)] = state_reg.prg[PRG_IDX_W'(0)];
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{variant: 1'b0, prg_mask: '1, chr_mask: '1, mirror: 1'b0,
                           prg: '0, chr: '0};
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

### hdl/cbm_wram.sv
`timescale 1ns / 1ps

module cbm_wram (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic                          rd_en,
    input  logic [cbm_pkg::WRAM_AW-1:0]   addr,
    input  logic [cbm_pkg::BYTE_W-1:0]    wr_data,
    output logic [cbm_pkg::BYTE_W-1:0]    rd_data
);
    import cbm_pkg::*;

    logic [BYTE_W-1:0]     mem [WRAM_DEPTH];
    logic [WRAM_DEPTH-1:0] vld_reg;
    logic [BYTE_W-1:0]     q_reg;
    logic                  hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[addr];
        end
    end

    // an entry never written since reset reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= vld_reg[addr];
            end
        end
    end

    assign rd_data = hit_reg ? q_reg : '0;

endmodule

### hdl/cbm_map.sv
`timescale 1ns / 1ps

module cbm_map (
    input  logic [cbm_pkg::MODE_W-1:0]      mode,
    input  logic [cbm_pkg::ADDR_W-1:0]      address,
    input  cbm_pkg::bank_state_t            state,
    output logic [cbm_pkg::TARGET_W-1:0]    target,
    output logic [cbm_pkg::MAP_ADDR_W-1:0]  mapped_address,
    output logic                            wram_read
);
    import cbm_pkg::*;

    logic [BYTE_W-1:0] prg_bank;
    logic [BYTE_W-1:0] chr_reg;
    logic [BYTE_W-1:0] chr_bank;
    logic [BYTE_W-1:0] nt_reg;
    logic              nt_page;
    logic              wram_hit;

    assign wram_hit = (address[ADDR_W-1:8] == WRAM_PAGE) && !state.variant;

    always_comb
    begin
        case (address[14:13])
            2'd0:    prg_bank = state.prg[PRG_IDX_W'(0)] & state.prg_mask;
            2'd1:    prg_bank = state.prg[PRG_IDX_W'(1)] & state.prg_mask;
            2'd2:    prg_bank = state.prg[PRG_IDX_W'(2)] & state.prg_mask;
            default: prg_bank = state.prg_mask;
        endcase
    end

    always_comb
    begin
        chr_reg = state.chr[{{(CHR_IDX_W-1){1'b0}}, address[11]}];
        if (state.variant)
        begin
            chr_reg[7] = 1'b0;
        end
        if (!address[12])
        begin
            chr_bank = {chr_reg[7:1], address[10]} & state.chr_mask;
        end
        else
        begin
            chr_bank = state.chr[CHR_IDX_W'(2) + {1'b0, address[11:10]}] & state.chr_mask;
        end
    end

    always_comb
    begin
        nt_reg = state.chr[{{(CHR_IDX_W-1){1'b0}}, address[11]}];
        if (state.variant)
        begin
            nt_page = nt_reg[7];
        end
        else if (state.mirror)
        begin
            nt_page = address[10];
        end
        else
        begin
            nt_page = address[11];
        end
    end

    always_comb
    begin
        target         = TGT_NONE;
        mapped_address = '0;
        wram_read      = 1'b0;
        case (mode)
            MODE_READ:
            begin
                if (address[15])
                begin
                    target         = TGT_PRG;
                    mapped_address = {prg_bank, address[12:0]};
                end
                else if (wram_hit)
                begin
                    target    = TGT_WRAM;
                    wram_read = 1'b1;
                end
            end
            MODE_PPU:
            begin
                if (!address[13])
                begin
                    target         = TGT_CHR;
                    mapped_address = {3'b000, chr_bank, address[9:0]};
                end
                else
                begin
                    target         = TGT_NT;
                    mapped_address = {10'd0, nt_page, address[9:0]};
                end
            end
            default:
            begin
                target = TGT_NONE;
            end
        endcase
    end

endmodule

### hdl/cartridge_bank_mapper_x1_005_top.sv
`timescale 1ns / 1ps
// Channel  Direction  Transaction carries
// req      in         mode, address, write_data
// rsp      out        target, mapped_address, read_data
// cfg_*    in         write of variant / prg_bank_mask / chr_bank_mask
//
// One transaction per cycle while rsp is not stalled; a result passes through the middle
// stage and the output register after accept. The work RAM read port is registered: the
// RAM byte lands in the cycle after accept and is joined with the translation held in the middle stage.
// Reset clears the bank registers, sets both masks to all ones and clears the
// 256 work RAM valid bits at once.
// A stalled rsp holds both stages; req.ready drops only when both are full and
// rsp is stalled.
module cartridge_bank_mapper_x1_005_top (
    input  logic                               clk,
    input  logic                               rst_n,
    cbm_req_if.sink                            req,
    cbm_rsp_if.source                          rsp,
    input  logic                               cfg_we,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cbm_pkg::*;

    bank_state_t             state;
    logic                    accept;
    logic                    move;
    logic                    out_free;
    logic                    is_write;
    logic                    wram_wr;
    logic [TARGET_W-1:0]     map_target;
    logic [MAP_ADDR_W-1:0]   map_addr;
    logic                    map_wram;
    logic [BYTE_W-1:0]       wram_data;

    logic                    s1_vld_reg;
    logic                    s1_vld_next;
    logic [TARGET_W-1:0]     s1_target_reg;
    logic [MAP_ADDR_W-1:0]   s1_addr_reg;
    logic                    s1_wram_reg;

    logic                    out_vld_reg;
    logic                    out_vld_next;
    logic [TARGET_W-1:0]     out_target_reg;
    logic [MAP_ADDR_W-1:0]   out_addr_reg;
    logic [BYTE_W-1:0]       out_data_reg;

    assign out_free  = !out_vld_reg || rsp.ready;
    assign move      = s1_vld_reg && out_free;
    assign req.ready = !s1_vld_reg || move;
    assign accept    = req.valid && req.ready;

    assign is_write = accept && (req.mode == MODE_WRITE);
    assign wram_wr  = is_write && (req.address[ADDR_W-1:8] == WRAM_PAGE) && !state.variant;

    cbm_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wr_en     (is_write),
        .wr_addr   (req.address),
        .wr_data   (req.write_data),
        .state     (state)
    );

    cbm_wram u_wram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wram_wr),
        .rd_en   (accept),
        .addr    (req.address[WRAM_AW-1:0]),
        .wr_data (req.write_data),
        .rd_data (wram_data)
    );

    cbm_map u_map (
        .mode           (req.mode),
        .address        (req.address),
        .state          (state),
        .target         (map_target),
        .mapped_address (map_addr),
        .wram_read      (map_wram)
    );

    assign s1_vld_next  = accept ? 1'b1 : (move ? 1'b0 : s1_vld_reg);
    assign out_vld_next = move ? 1'b1 : (rsp.ready ? 1'b0 : out_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_target_reg <= map_target;
            s1_addr_reg   <= map_addr;
            s1_wram_reg   <= map_wram;
        end
        if (move)
        begin
            out_target_reg <= s1_target_reg;
            out_addr_reg   <= s1_addr_reg;
            out_data_reg   <= s1_wram_reg ? wram_data : '0;
        end
    end

    assign rsp.valid          = out_vld_reg;
    assign rsp.target         = out_target_reg;
    assign rsp.mapped_address = out_addr_reg;
    assign rsp.read_data      = out_data_reg;

endmodule

### hdl/cbm_checker.sv
`timescale 1ns / 1ps

module cbm_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [2:0]  rsp_target,
    input  logic [20:0] rsp_mapped_address,
    input  logic [7:0]  rsp_read_data
);
    import cbm_pkg::*;

    // hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp valid dropped while stalled");

    a_data_only_wram: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_target != TGT_WRAM) |-> (rsp_read_data == '0))
        else $error("read data outside a work RAM read");

    a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_target == TGT_NONE || rsp_target == TGT_WRAM)
        |-> (rsp_mapped_address == '0))
        else $error("address on an unmapped result");

    a_nt_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_target == TGT_NT) |-> (rsp_mapped_address[20:11] == '0))
        else $error("nametable address beyond 2K");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("rsp valid during reset");

endmodule

bind cartridge_bank_mapper_x1_005_top cbm_checker u_cbm_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_target         (rsp.target),
    .rsp_mapped_address (rsp.mapped_address),
    .rsp_read_data      (rsp.read_data)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import cbm_pkg::*;

    // mode 3 is not an access; the block answers with no target
    localparam logic [MODE_W-1:0] MODE_IDLE = 2'd3;
    localparam int QUIET_LIMIT    = 2000;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 178;
    localparam int DRAIN_CYCLES   = 6;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] write_data;
    } access_t;

    typedef struct packed {
        logic [TARGET_W-1:0]   target;
        logic [MAP_ADDR_W-1:0] mapped_address;
        logic [BYTE_W-1:0]     read_data;
    } mapping_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cbm_req_if req_ch();
    cbm_rsp_if rsp_ch();

    cartridge_bank_mapper_x1_005_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mapper state as the predictor sees it
    logic              model_variant;
    logic [BYTE_W-1:0] prg_mask_reg;
    logic [BYTE_W-1:0] chr_mask_reg;
    logic [BYTE_W-1:0] prg_bank [PRG_REGS];
    logic [BYTE_W-1:0] chr_bank [CHR_REGS];
    logic              mirror_vertical;
    logic [BYTE_W-1:0] wram [WRAM_DEPTH];

    access_t  access_queue [$];
    mapping_t due_mappings [$];

    int send_idle_pct;
    int stall_pct;
    int queued_items;
    int accepted_items;
    int checked_results;
    int fail_count;
    int quiet_cycles;
    int target_count [8];

    function automatic mapping_t translate_access(access_t a);
        mapping_t          r;
        logic [BYTE_W-1:0] bank;
        logic [13:0]       pa;
        logic [1:0]        slot;
        logic              page;
        r = '0;
        case (a.mode)
            MODE_WRITE: begin
                if (a.address[15:4] == REG_PAGE) begin
                    if (a.address[3:0] <= REG_CHR_LAST)
                        chr_bank[a.address[2:0]] = a.write_data;
                    else if (a.address[3:0] == REG_MIRROR)
                        mirror_vertical = a.write_data[0];
                    else if (a.address[3:0] >= REG_PRG_FIRST)
                        prg_bank[(int'(a.address[3:0]) - int'(REG_PRG_FIRST)) >> 1] =
                            a.write_data;
                end else if (a.address[15:8] == WRAM_PAGE && !model_variant) begin
                    wram[a.address[7:0]] = a.write_data;
                end
            end
            MODE_READ: begin
                if (a.address[15]) begin
                    slot = a.address[14:13];
                    bank = (slot == 2'd3) ? prg_mask_reg : (prg_bank[slot] & prg_mask_reg);
                    r.target = TGT_PRG;
                    r.mapped_address = {bank, a.address[12:0]};
                end else if (a.address[15:8] == WRAM_PAGE && !model_variant) begin
                    r.target = TGT_WRAM;
                    r.read_data = wram[a.address[7:0]];
                end
            end
            MODE_PPU: begin
                pa = a.address[13:0];
                if (!pa[13]) begin
                    if (!pa[12]) begin
                        // 2K window: even bank from the register, A10 picks the half
                        bank = chr_bank[pa[11]];
                        if (model_variant)
                            bank[7] = 1'b0;
                        bank[0] = pa[10];
                    end else begin
                        bank = chr_bank[2 + pa[11:10]];
                    end
                    bank = bank & chr_mask_reg;
                    r.target = TGT_CHR;
                    r.mapped_address = MAP_ADDR_W'({bank, pa[9:0]});
                end else begin
                    slot = pa[11:10];
                    if (model_variant)
                        page = chr_bank[slot[1]][7];
                    else if (mirror_vertical)
                        page = slot[0];
                    else
                        page = slot[1];
                    r.target = TGT_NT;
                    r.mapped_address = MAP_ADDR_W'({page, pa[9:0]});
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic access_t random_access();
        access_t a;
        int      pick;
        a.mode = MODE_READ;
        a.address = 16'($urandom);
        a.write_data = 8'($urandom);
        if ($urandom_range(0, 9) == 0)
            a.write_data = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            a.mode = MODE_WRITE;
            a.address = {REG_PAGE, 4'($urandom)};
        end else if (pick < 45) begin
            // keep most work RAM traffic on a few bytes so reads hit written data
            a.mode = (pick < 35) ? MODE_WRITE : MODE_READ;
            a.address = {WRAM_PAGE, 8'($urandom)};
            if ($urandom_range(0, 1))
                a.address[7:0] = 8'($urandom_range(0, 15));
        end else if (pick < 65) begin
            a.address[15] = 1'b1;
        end else if (pick < 88) begin
            a.mode = MODE_PPU;
        end else if (pick < 96) begin
            a.mode = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
        end else begin
            a.mode = MODE_IDLE;
        end
        return a;
    endfunction

    task automatic push_access(input logic [MODE_W-1:0] mode, input logic [ADDR_W-1:0] addr,
                               input logic [BYTE_W-1:0] data);
        access_queue.push_back('{mode: mode, address: addr, write_data: data});
        queued_items++;
    endtask

    task automatic load_config(input logic v, input logic [BYTE_W-1:0] pm,
                               input logic [BYTE_W-1:0] cm);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_VARIANT;
        cfg_data  <= CFG_DATA_W'(v);
        @(posedge clk);
        cfg_index <= CFG_PRG_MASK;
        cfg_data  <= pm;
        @(posedge clk);
        cfg_index <= CFG_CHR_MASK;
        cfg_data  <= cm;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_variant = v;
        prg_mask_reg  = pm;
        chr_mask_reg  = cm;
    endtask

    task automatic drain();
        while (access_queue.size() != 0 || accepted_items != queued_items
               || due_mappings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // request driver: hold the transaction until accepted, then advance
    always @(posedge clk)
    begin
        access_t nxt;
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (access_queue.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
                nxt = access_queue.pop_front();
                req_ch.valid      <= 1'b1;
                req_ch.mode       <= nxt.mode;
                req_ch.address    <= nxt.address;
                req_ch.write_data <= nxt.write_data;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= ($urandom_range(1, 100) > stall_pct);
    end

    // monitor: predict on request accept, compare on response accept
    always @(posedge clk)
    begin
        mapping_t exp;
        if (rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                exp = translate_access('{mode: req_ch.mode, address: req_ch.address,
                                         write_data: req_ch.write_data});
                due_mappings.push_back(exp);
                target_count[exp.target]++;
                accepted_items++;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                checked_results++;
                if (due_mappings.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result target=%0d addr=%h data=%h", $time,
                             rsp_ch.target, rsp_ch.mapped_address, rsp_ch.read_data);
                end else begin
                    exp = due_mappings.pop_front();
                    if (rsp_ch.target !== exp.target) begin
                        fail_count++;
                        $display("%0t: target expected %0d actual %0d", $time,
                                 exp.target, rsp_ch.target);
                    end
                    if (rsp_ch.mapped_address !== exp.mapped_address) begin
                        fail_count++;
                        $display("%0t: mapped_address expected %h actual %h", $time,
                                 exp.mapped_address, rsp_ch.mapped_address);
                    end
                    if (rsp_ch.read_data !== exp.read_data) begin
                        fail_count++;
                        $display("%0t: read_data expected %h actual %h", $time,
                                 exp.read_data, rsp_ch.read_data);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic              ph_variant [PHASES];
        logic [BYTE_W-1:0] ph_prg [PHASES];
        logic [BYTE_W-1:0] ph_chr [PHASES];
        int                idle_send [4];
        int                idle_recv [4];

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_WRITE;
        req_ch.address = '0;
        req_ch.write_data = '0;
        rsp_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_VARIANT;
        cfg_data = '0;
        model_variant = 1'b0;
        prg_mask_reg = 8'hFF;
        chr_mask_reg = 8'hFF;
        mirror_vertical = 1'b0;
        foreach (prg_bank[i]) prg_bank[i] = '0;
        foreach (chr_bank[i]) chr_bank[i] = '0;
        foreach (wram[i]) wram[i] = '0;
        foreach (target_count[i]) target_count[i] = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        queued_items = 0;
        accepted_items = 0;
        checked_results = 0;
        fail_count = 0;
        quiet_cycles = 0;

        idle_send = '{0, 76, 0, 11};
        idle_recv = '{0, 0, 76, 11};
        ph_variant = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        ph_prg = '{8'hFF, 8'hFF, 8'h00, 8'h1F, 8'($urandom), 8'h00, 8'h7F, 8'($urandom)};
        ph_chr = '{8'hFF, 8'hFF, 8'h00, 8'h7F, 8'($urandom), 8'hFF, 8'h03, 8'($urandom)};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass at reset settings
        push_access(MODE_READ,  16'h7F00, 8'h00);  // cleared work RAM
        push_access(MODE_WRITE, 16'h7EF0, 8'hFF);
        push_access(MODE_WRITE, 16'h7EF1, 8'h80);
        push_access(MODE_WRITE, 16'h7EF2, 8'hFF);
        push_access(MODE_WRITE, 16'h7EF5, 8'h3C);
        push_access(MODE_WRITE, 16'h7EF6, 8'hFE);  // only bit 0 counts
        push_access(MODE_WRITE, 16'h7EF6, 8'hFF);
        push_access(MODE_WRITE, 16'h7EF8, 8'h55);  // ignored
        push_access(MODE_WRITE, 16'h7EF7, 8'h12);  // ignored
        push_access(MODE_WRITE, 16'h7EFA, 8'hFF);
        push_access(MODE_WRITE, 16'h7EFD, 8'h21);
        push_access(MODE_WRITE, 16'h7EFF, 8'h40);
        push_access(MODE_WRITE, 16'h7F00, 8'hA5);
        push_access(MODE_WRITE, 16'h7FFF, 8'h5A);
        push_access(MODE_READ,  16'h7FFF, 8'hFF);
        push_access(MODE_READ,  16'h8000, 8'h00);
        push_access(MODE_READ,  16'hFFFF, 8'h00);
        push_access(MODE_READ,  16'h0000, 8'h00);
        push_access(MODE_PPU,   16'h0400, 8'h00);
        push_access(MODE_PPU,   16'h0C00, 8'h00);
        push_access(MODE_PPU,   16'h1FFF, 8'h00);
        push_access(MODE_PPU,   16'h2C00, 8'h00);
        push_access(MODE_PPU,   16'h3FFF, 8'h00);
        push_access(MODE_PPU,   16'hFFFF, 8'h00);  // upper address bits dropped
        push_access(MODE_IDLE,  16'hFFFF, 8'hFF);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            load_config(ph_variant[p], ph_prg[p], ph_chr[p]);
            send_idle_pct = idle_send[p % 4];
            stall_pct = idle_recv[p % 4];
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                access_queue.push_back(random_access());
                queued_items++;
            end
            drain();
        end

        if (due_mappings.size() != 0) begin
            fail_count++;
            $display("%0t: %0d expected results never arrived", $time, due_mappings.size());
        end
        $display("Ran %0d accesses over %0d settings; %0d results checked, %0d mismatches",
                 accepted_items, PHASES + 1, checked_results, fail_count);
        $display("Results: none %0d, work RAM %0d, program %0d, character %0d, nametable %0d",
                 target_count[TGT_NONE], target_count[TGT_WRAM], target_count[TGT_PRG],
                 target_count[TGT_CHR], target_count[TGT_NT]);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### cartridge_bank_mapper_x1_005_top.f
hdl/cbm_pkg.sv
hdl/cbm_if.sv
hdl/cbm_regs.sv
hdl/cbm_wram.sv
hdl/cbm_map.sv
hdl/cartridge_bank_mapper_x1_005_top.sv
hdl/cbm_checker.sv
tb/sv/testbench.sv
